>>> hw/rtl/mke_pkg.sv
// Package with shared types, constants and the character code table of the Morse keying encoder.
`default_nettype none

package mke_pkg;

	localparam int CHAR_W     = 8;
	localparam int SPEED_W    = 9;
	localparam int DIVIDEND_W = 13;
	localparam int DOT_W      = 10;
	localparam int DUR_W      = 11;
	localparam int PAT_W      = 6;
	localparam int LEN_W      = 3;

	localparam logic [DIVIDEND_W-1:0] WPM_DIVIDEND = 13'd1200;
	localparam logic [DIVIDEND_W-1:0] CPM_DIVIDEND = 13'd6000;

	localparam logic [SPEED_W-1:0] WPM_MIN = 9'd5;
	localparam logic [SPEED_W-1:0] WPM_MAX = 9'd50;
	localparam logic [SPEED_W-1:0] CPM_MIN = 9'd9;
	localparam logic [SPEED_W-1:0] CPM_MAX = 9'd275;

	localparam logic REG_SPEED_MODE = 1'b0;
	localparam logic REG_SPEED      = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERROR,
		ST_DIVIDE,
		ST_MARK,
		ST_GAP,
		ST_WORD,
		ST_TAIL
	} state_t;

	// Elements are left aligned in pat, first element in the top bit, 1 = dash.
	typedef struct packed {
		logic             valid;
		logic             space;
		logic [LEN_W-1:0] len;
		logic [PAT_W-1:0] pat;
	} code_t;

	function automatic code_t code_of(input logic [CHAR_W-1:0] ch);
		logic [CHAR_W-1:0] c;
		code_t             r;
		c = ch;
		if (ch >= 8'h61 && ch <= 8'h7A) begin
			c = ch - 8'd32;
		end
		r = '{valid: 1'b1, space: 1'b0, len: 3'd0, pat: 6'b000000};
		unique case (c)
			8'h30: begin r.len = 3'd5; r.pat = 6'b111110; end
			8'h31: begin r.len = 3'd5; r.pat = 6'b011110; end
			8'h32: begin r.len = 3'd5; r.pat = 6'b001110; end
			8'h33: begin r.len = 3'd5; r.pat = 6'b000110; end
			8'h34: begin r.len = 3'd5; r.pat = 6'b000010; end
			8'h35: begin r.len = 3'd5; r.pat = 6'b000000; end
			8'h36: begin r.len = 3'd5; r.pat = 6'b100000; end
			8'h37: begin r.len = 3'd5; r.pat = 6'b110000; end
			8'h38: begin r.len = 3'd5; r.pat = 6'b111000; end
			8'h39: begin r.len = 3'd5; r.pat = 6'b111100; end
			8'h41: begin r.len = 3'd2; r.pat = 6'b010000; end
			8'h42: begin r.len = 3'd4; r.pat = 6'b100000; end
			8'h43: begin r.len = 3'd4; r.pat = 6'b101000; end
			8'h44: begin r.len = 3'd3; r.pat = 6'b100000; end
			8'h45: begin r.len = 3'd1; r.pat = 6'b000000; end
			8'h46: begin r.len = 3'd4; r.pat = 6'b001000; end
			8'h47: begin r.len = 3'd3; r.pat = 6'b110000; end
			8'h48: begin r.len = 3'd4; r.pat = 6'b000000; end
			8'h49: begin r.len = 3'd2; r.pat = 6'b000000; end
			8'h4A: begin r.len = 3'd4; r.pat = 6'b011100; end
			8'h4B: begin r.len = 3'd3; r.pat = 6'b101000; end
			8'h4C: begin r.len = 3'd4; r.pat = 6'b010000; end
			8'h4D: begin r.len = 3'd2; r.pat = 6'b110000; end
			8'h4E: begin r.len = 3'd2; r.pat = 6'b100000; end
			8'h4F: begin r.len = 3'd3; r.pat = 6'b111000; end
			8'h50: begin r.len = 3'd4; r.pat = 6'b011000; end
			8'h51: begin r.len = 3'd4; r.pat = 6'b110100; end
			8'h52: begin r.len = 3'd3; r.pat = 6'b010000; end
			8'h53: begin r.len = 3'd3; r.pat = 6'b000000; end
			8'h54: begin r.len = 3'd1; r.pat = 6'b100000; end
			8'h55: begin r.len = 3'd3; r.pat = 6'b001000; end
			8'h56: begin r.len = 3'd4; r.pat = 6'b000100; end
			8'h57: begin r.len = 3'd3; r.pat = 6'b011000; end
			8'h58: begin r.len = 3'd4; r.pat = 6'b100100; end
			8'h59: begin r.len = 3'd4; r.pat = 6'b101100; end
			8'h5A: begin r.len = 3'd4; r.pat = 6'b110000; end
			8'h2E: begin r.len = 3'd6; r.pat = 6'b010101; end
			8'h2C: begin r.len = 3'd6; r.pat = 6'b110011; end
			8'h2F: begin r.len = 3'd5; r.pat = 6'b100100; end
			8'h3D: begin r.len = 3'd5; r.pat = 6'b100010; end
			8'h2D: begin r.len = 3'd6; r.pat = 6'b100001; end
			8'h3F: begin r.len = 3'd6; r.pat = 6'b001100; end
			8'h20: begin r.space = 1'b1; end
			default: begin r.valid = 1'b0; end
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mke_div.sv
// Restoring divider that produces one quotient bit per clock for the dot length.
`default_nettype none

module mke_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic [mke_pkg::DIVIDEND_W-1:0]  dividend,
	input  wire logic [mke_pkg::SPEED_W-1:0]     divisor,
	output logic                                 done,
	output logic [mke_pkg::DOT_W-1:0]            quotient
);
	import mke_pkg::*;

	localparam int CNT_W = $clog2(DIVIDEND_W);

	logic                  run_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [SPEED_W-1:0]    divisor_q;
	logic [SPEED_W-1:0]    rem_q;
	logic [DIVIDEND_W-1:0] quo_q;

	logic [SPEED_W:0]      shifted;
	logic [SPEED_W+1:0]    diff;
	logic                  ge;

	// One trial subtraction per cycle.
	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, divisor_q};
	assign ge      = ~diff[SPEED_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			divisor_q <= divisor;
			rem_q     <= '0;
			quo_q     <= dividend;
		end else if (run_q) begin
			rem_q <= ge ? diff[SPEED_W-1:0] : shifted[SPEED_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q[DOT_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/morse_keying_encoder_unit.sv
// Top level of the Morse keying encoder: register file, sequencer and period output.
// An error result appears in the cycle after the start transaction; otherwise the
// first keying period comes once the 13-step bit-serial divider is done. A character
// gives 2 to 13 periods, a rejected one an error period; busy stays high until the last
// one, blocking new ones. Results are strobed for one cycle each and cannot be stalled.
// Reset (arst_n low, asynchronous) returns to idle with speed_mode 0 and speed 20.
`default_nettype none

module morse_keying_encoder_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_write,
	input  wire logic                          cfg_index,
	input  wire logic [mke_pkg::SPEED_W-1:0]   cfg_data,
	input  wire logic                          start,
	input  wire logic [mke_pkg::CHAR_W-1:0]    character,
	output logic                               busy,
	output logic                               strobe,
	output logic                               key_on,
	output logic [mke_pkg::DUR_W-1:0]          duration_ms,
	output logic                               error,
	output logic                               last
);
	import mke_pkg::*;

	// Configuration registers, read directly at the start transaction. The user must
	// change them only while the block is idle; the block itself does not enforce this.
	logic               speed_mode_q;
	logic [SPEED_W-1:0] speed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_mode_q <= 1'b0;
			speed_q      <= 9'd20;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_SPEED_MODE: speed_mode_q <= cfg_data[0];
				REG_SPEED:      speed_q      <= cfg_data;
			endcase
		end
	end

	// Character lookup and speed range check for the incoming transaction.
	code_t code;
	logic  speed_ok;
	logic  accept;

	assign code     = code_of(character);
	assign speed_ok = speed_mode_q ? (speed_q >= CPM_MIN && speed_q <= CPM_MAX)
	                               : (speed_q >= WPM_MIN && speed_q <= WPM_MAX);

	// The dot length is a constant divided by the speed; the divider
	// works one quotient bit per cycle and holds its result afterwards.
	logic                  div_start;
	logic                  div_done;
	logic [DOT_W-1:0]      dot;
	logic [DUR_W-1:0]      dot3;

	mke_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (speed_mode_q ? CPM_DIVIDEND : WPM_DIVIDEND),
		.divisor  (speed_q),
		.done     (div_done),
		.quotient (dot)
	);

	// Three dots as dot plus twice dot; the largest dot (666) keeps this within 11 bits.
	assign dot3 = {1'b0, dot} + {dot, 1'b0};

	// Sequencer state. pat_q shifts left once per element so its top bit always
	// tells whether the current element is a dash; left_q counts elements still to send.
	state_t           state_q;
	state_t           state_d;
	logic [PAT_W-1:0] pat_q;
	logic [LEN_W-1:0] left_q;
	logic             word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pat_q  <= code.pat;
			left_q <= code.len;
			word_q <= code.space;
		end else if (state_q == ST_GAP) begin
			pat_q  <= {pat_q[PAT_W-2:0], 1'b0};
			left_q <= left_q - 1'b1;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		state_d     = state_q;
		div_start   = 1'b0;
		strobe      = 1'b0;
		key_on      = 1'b0;
		duration_ms = '0;
		error       = 1'b0;
		last        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (speed_ok && code.valid) begin
						div_start = 1'b1;
						state_d   = ST_DIVIDE;
					end else begin
						state_d = ST_ERROR;
					end
				end
			end
			ST_ERROR: begin
				// Rejected character or speed out of range: a single zero-length period.
				strobe  = 1'b1;
				error   = 1'b1;
				last    = 1'b1;
				state_d = ST_IDLE;
			end
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = word_q ? ST_WORD : ST_MARK;
				end
			end
			ST_MARK: begin
				strobe      = 1'b1;
				key_on      = 1'b1;
				duration_ms = pat_q[PAT_W-1] ? dot3 : {1'b0, dot};
				state_d     = ST_GAP;
			end
			ST_GAP: begin
				strobe      = 1'b1;
				duration_ms = {1'b0, dot};
				state_d     = (left_q == LEN_W'(1)) ? ST_TAIL : ST_MARK;
			end
			ST_WORD: begin
				// A space sends an extra character pause ahead of the usual one.
				strobe      = 1'b1;
				duration_ms = dot3;
				state_d     = ST_TAIL;
			end
			ST_TAIL: begin
				strobe      = 1'b1;
				duration_ms = dot3;
				last        = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> bench/morse_keying_encoder_unit_tb.sv
// Self-checking testbench for the Morse keying encoder: directed and random characters with a scoreboard.

module morse_keying_encoder_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import mke_pkg::*;

	// The run is cut off here if the block hangs; the limit leaves a wide margin over the
	// length of a correct run.
	localparam int CYCLE_LIMIT = 100000;

	// Characters for the opening directed part: both ends of the letter and digit ranges,
	// a lower case letter, every punctuation mark, the space, and a few rejected bytes
	// (NUL, the top byte, the first byte above 7-bit ASCII, and the code just below 'A').
	localparam logic [CHAR_W-1:0] OPENING_CHARS [15] = '{
		8'h41, 8'h7A, 8'h30, 8'h39, 8'h2E, 8'h2C, 8'h2F, 8'h3D,
		8'h2D, 8'h3F, 8'h20, 8'h00, 8'hFF, 8'h80, 8'h40
	};

	// One keying period as the block reports it.
	typedef struct packed {
		logic             key;
		logic [DUR_W-1:0] dur;
		logic             err;
		logic             fin;
	} period_t;

	// Keeps its own copy of the two registers, expands each accepted character into the
	// periods it must produce, and checks the strobed periods in order against them.
	class keying_scoreboard;
		period_t              expected_periods[$];
		logic                 wpm_or_cpm;
		logic [SPEED_W-1:0]   rate;
		int                   mismatch_count;
		string                morse_code[42];

		function new();
			wpm_or_cpm = 1'b0;
			rate = 9'd20;
			mismatch_count = 0;
			morse_code = '{
				"-----", ".----", "..---", "...--", "....-",
				".....", "-....", "--...", "---..", "----.",
				".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
				"-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
				"..-", "...-", ".--", "-..-", "-.--", "--..",
				".-.-.-", "--..--", "-..-.", "-...-", "-....-", "..--.."
			};
		endfunction

		function void set_register(logic idx, logic [SPEED_W-1:0] data);
			if (idx == REG_SPEED_MODE) begin
				wpm_or_cpm = data[0];
			end else begin
				rate = data;
			end
		endfunction

		// Row in the code table, 42 for the word space, -1 when the byte is rejected.
		function int row_for(logic [CHAR_W-1:0] c);
			if (c >= "A" && c <= "Z") begin
				return int'(c) - int'("A") + 10;
			end
			if (c >= "0" && c <= "9") begin
				return int'(c) - int'("0");
			end
			case (c)
				".": return 36;
				",": return 37;
				"/": return 38;
				"=": return 39;
				"-": return 40;
				"?": return 41;
				" ": return 42;
				default: return -1;
			endcase
		endfunction

		function period_t period_of(logic key, int dur, logic err, logic fin);
			period_t p;
			p.key = key;
			p.dur = DUR_W'(dur);
			p.err = err;
			p.fin = fin;
			return p;
		endfunction

		function void note_character(logic [CHAR_W-1:0] ch);
			logic [CHAR_W-1:0] c;
			int                sp;
			int                dot;
			int                row;
			bit                in_range;
			string             code;
			sp = int'(rate);
			if (!wpm_or_cpm) begin
				in_range = sp >= 5 && sp <= 50;
				dot = in_range ? 1200 / sp : 0;
			end else begin
				in_range = sp >= 9 && sp <= 275;
				dot = in_range ? 6000 / sp : 0;
			end
			c = ch;
			if (c >= "a" && c <= "z") begin
				c = c - 8'd32;
			end
			row = row_for(c);
			// A bad speed or a rejected byte collapses to one error period.
			if (!in_range || row < 0) begin
				expected_periods.push_back(period_of(1'b0, 0, 1'b1, 1'b1));
				return;
			end
			if (row == 42) begin
				expected_periods.push_back(period_of(1'b0, 3 * dot, 1'b0, 1'b0));
			end else begin
				code = morse_code[row];
				for (int i = 0; i < code.len(); i++) begin
					expected_periods.push_back(
						period_of(1'b1, (code[i] == "-") ? 3 * dot : dot, 1'b0, 1'b0));
					expected_periods.push_back(period_of(1'b0, dot, 1'b0, 1'b0));
				end
			end
			// Every accepted character closes with the three-dot letter gap, flagged as last.
			expected_periods.push_back(period_of(1'b0, 3 * dot, 1'b0, 1'b1));
		endfunction

		function void check_period(period_t got);
			period_t want;
			if (expected_periods.size() == 0) begin
				if (mismatch_count < 10) begin
					$display("unexpected period: key_on=%0b duration_ms=%0d error=%0b last=%0b",
						got.key, got.dur, got.err, got.fin);
				end
				mismatch_count++;
				return;
			end
			want = expected_periods.pop_front();
			if (got.key !== want.key || got.dur !== want.dur ||
					got.err !== want.err || got.fin !== want.fin) begin
				if (mismatch_count < 10) begin
					$display("period mismatch at %0t: expected key_on=%0b duration_ms=%0d error=%0b last=%0b, got key_on=%0b duration_ms=%0d error=%0b last=%0b",
						$realtime, want.key, want.dur, want.err, want.fin,
						got.key, got.dur, got.err, got.fin);
				end
				mismatch_count++;
			end
		endfunction

		function int pending();
			return expected_periods.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic                 cfg_index = REG_SPEED_MODE;
	logic [SPEED_W-1:0]   cfg_data = '0;
	logic                 start = 1'b0;
	logic [CHAR_W-1:0]    character = '0;
	logic                 busy;
	logic                 strobe;
	logic                 key_on;
	logic [DUR_W-1:0]     duration_ms;
	logic                 error;
	logic                 last;

	keying_scoreboard     sb;
	int                   cycle_count = 0;

	morse_keying_encoder_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.character   (character),
		.busy        (busy),
		.strobe      (strobe),
		.key_on      (key_on),
		.duration_ms (duration_ms),
		.error       (error),
		.last        (last)
	);

	// 4 ns clock period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Every strobed period is checked at the edge that closes its cycle; the block's
	// outputs still hold their pre-edge values when this process runs.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			sb.check_period('{key: key_on, dur: duration_ms, err: error, fin: last});
		end
	end

	// Watchdog: a hang anywhere ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Register write: one cycle with the write enable high, then a wait with it low so that
	// back-to-back writes never lower and raise the enable in the same time step.
	task automatic write_register(input logic idx, input logic [SPEED_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_register(idx, data);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Presents one character and holds it until the transaction is taken, that is, at
	// an edge where start is high and busy is low. The prediction is made right there.
	task automatic send_character(input logic [CHAR_W-1:0] ch);
		start <= 1'b1;
		character <= ch;
		do @(posedge clk); while (busy);
		sb.note_character(ch);
	endtask

	// Stops sending and waits until every predicted period has come out and the block
	// has dropped busy. Must directly follow a send so that start is lowered only once.
	task automatic drain();
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		while (busy) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// The block must be idle for a register change, so each new setting starts by
	// draining whatever is still in flight.
	task automatic apply_setting(input logic [SPEED_W-1:0] mode_data,
			input logic [SPEED_W-1:0] speed_data);
		drain();
		write_register(REG_SPEED_MODE, mode_data);
		write_register(REG_SPEED, speed_data);
	endtask

	// Mostly characters from the accepted set with a random case for letters; the rest
	// are arbitrary bytes, which land on control codes, high bytes and stray punctuation.
	function automatic logic [CHAR_W-1:0] pick_character();
		int k;
		if ($urandom_range(0, 3) == 0) begin
			return CHAR_W'($urandom_range(0, 255));
		end
		k = $urandom_range(0, 42);
		if (k < 10) begin
			return CHAR_W'(int'("0") + k);
		end
		if (k < 36) begin
			return CHAR_W'(int'("A") + k - 10 + ($urandom_range(0, 1) ? 32 : 0));
		end
		case (k)
			36: return ".";
			37: return ",";
			38: return "/";
			39: return "=";
			40: return "-";
			41: return "?";
			default: return " ";
		endcase
	endfunction

	// Picks a speed for a random phase: mostly inside the legal window of the mode, now
	// and then exactly on one of its edges, and sometimes anywhere in the 9-bit range.
	function automatic logic [SPEED_W-1:0] pick_speed(input logic cpm);
		int lo;
		int hi;
		int r;
		lo = cpm ? int'(CPM_MIN) : int'(WPM_MIN);
		hi = cpm ? int'(CPM_MAX) : int'(WPM_MAX);
		r = $urandom_range(0, 9);
		if (r < 7) begin
			return SPEED_W'($urandom_range(lo, hi));
		end
		if (r == 7) begin
			return SPEED_W'($urandom_range(0, 1) ? hi : lo);
		end
		return SPEED_W'($urandom_range(0, 511));
	endfunction

	initial begin
		logic cpm;
		bit   idling;

		sb = new();

		// Reset is held low from the start of the run and released on a clock edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed characters at the reset setting: 20 WPM, a 60 ms dot.
		foreach (OPENING_CHARS[i]) begin
			send_character(OPENING_CHARS[i]);
		end

		// Speed edges in both modes, each just inside and just outside the window, plus
		// zero and the all-ones speed. The digit zero gives the longest on periods and
		// the comma the most periods per character. Some mode writes carry junk in the
		// upper data bits, which the block must drop.
		apply_setting(9'h1FE, 9'd5);
		send_character("0");
		apply_setting(9'h000, 9'd50);
		send_character(",");
		apply_setting(9'h000, 9'd4);
		send_character("E");
		apply_setting(9'h000, 9'd51);
		send_character("T");
		apply_setting(9'h000, 9'd0);
		send_character("0");
		apply_setting(9'h1FE, 9'h1FF);
		send_character("?");
		apply_setting(9'h1FF, 9'd9);
		send_character("0");
		apply_setting(9'h001, 9'd275);
		send_character(",");
		apply_setting(9'h001, 9'd8);
		send_character("a");
		apply_setting(9'h001, 9'd276);
		send_character(" ");

		// Random part: five phases of twenty characters, each under a fresh setting.
		// Phase two runs with the sender never idling; in phase four the sender stops
		// halfway and waits for the block to empty completely before carrying on.
		for (int phase = 0; phase < 5; phase++) begin
			cpm = $urandom_range(0, 1);
			apply_setting({8'($urandom_range(0, 255)), cpm}, pick_speed(cpm));
			idling = (phase != 2);
			for (int n = 0; n < 20; n++) begin
				if (phase == 4 && n == 10) begin
					drain();
				end else if (idling && $urandom_range(0, 99) < 17) begin
					// Gap lengths up to well past a character's busy time, so the pause
					// ends in every stage of the block's work.
					start <= 1'b0;
					repeat ($urandom_range(1, 40)) @(posedge clk);
				end
				send_character(pick_character());
			end
		end

		// Let everything come out, then give the block a little longer in case it emits
		// anything it should not.
		drain();
		repeat (16) @(posedge clk);

		if (sb.mismatch_count == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

>>> morse_keying_encoder_unit.f
hw/rtl/mke_pkg.sv
hw/rtl/mke_div.sv
hw/rtl/morse_keying_encoder_unit.sv
bench/morse_keying_encoder_unit_tb.sv
